// ===== hw/rtl/nga_pkg.sv =====
// Shared types and constants for the nodal gradient area averaging unit.
// Depends on nothing; every other file of the block but nga_check imports it.
`default_nettype none
package nga_pkg;

  localparam int NodeCountDef = 1024;
  localparam int NodeW        = 10;
  localparam int ValW         = 32;
  localparam int AreaW        = 48;
  localparam int SumW         = 64;
  localparam int PartW        = 50;
  localparam int MagW         = 49;
  localparam int DivSteps     = 80;

  // floor(w / 3) = (w * ceil(2^33 / 3)) >> 33 for any 32-bit w
  localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;
  localparam logic [AreaW-1:0] AreaMax = {AreaW{1'b1}};

  typedef enum logic [1:0] {
    REQ_VERTEX = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [NodeW-1:0]      node;
    logic [ValW-1:0]       coef;
    logic signed [SumW-1:0] wx;
    logic signed [SumW-1:0] wy;
  } cmd_t;

  typedef struct packed {
    logic [AreaW-1:0]       area;
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
  } ent_t;

endpackage
`default_nettype wire

// ===== hw/rtl/nodal_gradient_area_average_unit.sv =====
// Area-weighted nodal gradient recovery for linear triangles. Requests are
// triangle vertices (three per element), node reads and node clears. After
// reset the unit sweeps all NODE_COUNT entries (1024 by default) of its
// node memory to zero, one entry per cycle; in_stall stays high meanwhile.
// A vertex passes the front's idle, multiply and accumulate states; the
// third vertex of an active element goes on through the coefficient, weigh
// and combine states and queues three node updates, each read in the back's
// idle state and written in its data state. A clear is written in the idle
// state; a read of a node with area above the threshold register waits for
// the 80-step bit-serial divider, a small-area read does not. A two-entry
// queue lets the front keep accepting while the back works, and the output
// register holds a result until taken. Depends on nga_pkg and submodules.
`default_nettype none
module nodal_gradient_area_average_unit
  import nga_pkg::*;
#(
  parameter int NODE_COUNT = NodeCountDef
)
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire [ValW-1:0]         cfg_wr_data,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire [1:0]              in_req_type,
  input  wire [NodeW-1:0]        in_node_index,
  input  wire signed [ValW-1:0]  in_scalar_value,
  input  wire signed [ValW-1:0]  in_shape_grad_x,
  input  wire signed [ValW-1:0]  in_shape_grad_y,
  input  wire [ValW-1:0]         in_elem_weight,
  input  wire                    in_element_active,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic signed [ValW-1:0] out_grad_x,
  output logic signed [ValW-1:0] out_grad_y,
  output logic                   out_area_small
);

  logic [ValW-1:0] thr_r;
  logic            clearing, push, full, pop, empty;
  cmd_t            push_data, head;

  // The threshold register resets to the smallest nonzero Q16.16 value.
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 32'd1;
    else if (cfg_wr_en) thr_r <= cfg_wr_data;
  end

  // The front part classifies each request and builds element weights.
  nga_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .clearing          (clearing),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_node_index     (in_node_index),
    .in_scalar_value   (in_scalar_value),
    .in_shape_grad_x   (in_shape_grad_x),
    .in_shape_grad_y   (in_shape_grad_y),
    .in_elem_weight    (in_elem_weight),
    .in_element_active (in_element_active),
    .push              (push),
    .push_data         (push_data),
    .full              (full)
  );

  // Node commands wait here in request order.
  nga_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // The back part owns the node memory and the result register.
  nga_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .threshold      (thr_r),
    .clearing       (clearing),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_grad_x     (out_grad_x),
    .out_grad_y     (out_grad_y),
    .out_area_small (out_area_small)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/nga_fifo.sv =====
// Two-entry command queue between the front and back parts.
// Depends on nga_pkg for the command type.
`default_nettype none
module nga_fifo
  import nga_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  cmd_t push_data,
  output logic full,
  input  wire  pop,
  output cmd_t head,
  output logic empty
);

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/nga_front.sv =====
// Front part: accepts requests, builds the element gradient and its weights,
// and queues node commands. Depends on nga_pkg.
`default_nettype none
module nga_front
  import nga_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   clearing,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [1:0]             in_req_type,
  input  wire [NodeW-1:0]       in_node_index,
  input  wire signed [ValW-1:0] in_scalar_value,
  input  wire signed [ValW-1:0] in_shape_grad_x,
  input  wire signed [ValW-1:0] in_shape_grad_y,
  input  wire [ValW-1:0]        in_elem_weight,
  input  wire                   in_element_active,
  output logic                  push,
  output cmd_t                  push_data,
  input  wire                   full
);

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_ACC, F_COEF, F_WEIGH, F_COMB, F_PUSH
  } fst_t;

  fst_t                    st_r;
  logic [1:0]              vcnt_r, k_r;
  logic [NodeW-1:0]        vnode_r [3];
  logic signed [ValW-1:0]  v_r, gx_r, gy_r;
  logic [ValW-1:0]         w_r, coef_r;
  logic                    act_r, negx_r, negy_r;
  logic signed [63:0]      px_r, py_r;
  logic signed [PartW-1:0] partx_r, party_r;
  logic [MagW-1:0]         magx_r, magy_r;
  logic [48:0]             hx_r, hy_r;
  logic [63:0]             lx_r, ly_r;
  logic signed [SumW-1:0]  wx_r, wy_r;

  logic                    in_acc;
  logic signed [63:0]      tx, ty;
  logic signed [PartW-1:0] sumx, sumy;
  logic [63:0]             wprod;
  logic [64:0]             rx, ry;

  assign in_stall = (st_r != F_IDLE) || clearing || full;
  assign in_acc   = in_valid && !in_stall;

  // Truncating division by 2^16: bias negative products before the shift.
  assign tx   = (px_r + (px_r[63] ? 64'sd65535 : 64'sd0)) >>> 16;
  assign ty   = (py_r + (py_r[63] ? 64'sd65535 : 64'sd0)) >>> 16;
  assign sumx = partx_r + tx[PartW-1:0];
  assign sumy = party_r + ty[PartW-1:0];
  assign wprod = {32'd0, w_r} * {32'd0, Recip3};
  assign rx = {hx_r, 16'd0} + {17'd0, lx_r[63:16]};
  assign ry = {hy_r, 16'd0} + {17'd0, ly_r[63:16]};

  always_comb begin
    push      = 1'b0;
    push_data = '{op: OP_UPDATE, node: vnode_r[k_r], coef: coef_r, wx: wx_r, wy: wy_r};
    if (st_r == F_PUSH && !full) begin
      push = 1'b1;
    end else if (in_acc && (in_req_type == REQ_READ || in_req_type == REQ_CLEAR)) begin
      push           = 1'b1;
      push_data.op   = (in_req_type == REQ_READ) ? OP_READ : OP_CLEAR;
      push_data.node = in_node_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      vcnt_r  <= 2'd0;
      k_r     <= 2'd0;
      partx_r <= '0;
      party_r <= '0;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (in_acc && in_req_type == REQ_VERTEX) begin
            vnode_r[vcnt_r] <= in_node_index;
            v_r   <= in_scalar_value;
            gx_r  <= in_shape_grad_x;
            gy_r  <= in_shape_grad_y;
            w_r   <= in_elem_weight;
            act_r <= in_element_active;
            st_r  <= F_MUL;
          end
        end
        F_MUL: begin
          px_r <= 64'(v_r) * 64'(gx_r);
          py_r <= 64'(v_r) * 64'(gy_r);
          st_r <= F_ACC;
        end
        F_ACC: begin
          if (vcnt_r != 2'd2) begin
            partx_r <= sumx;
            party_r <= sumy;
            vcnt_r  <= vcnt_r + 2'd1;
            st_r    <= F_IDLE;
          end else if (!act_r) begin
            vcnt_r  <= 2'd0;
            partx_r <= '0;
            party_r <= '0;
            st_r    <= F_IDLE;
          end else begin
            partx_r <= sumx;
            party_r <= sumy;
            st_r    <= F_COEF;
          end
        end
        F_COEF: begin
          coef_r <= {1'b0, wprod[63:33]};
          negx_r <= partx_r[PartW-1];
          negy_r <= party_r[PartW-1];
          magx_r <= partx_r[PartW-1] ? MagW'(-partx_r) : MagW'(partx_r);
          magy_r <= party_r[PartW-1] ? MagW'(-party_r) : MagW'(party_r);
          st_r   <= F_WEIGH;
        end
        F_WEIGH: begin
          hx_r <= {32'd0, magx_r[48:32]} * {17'd0, coef_r};
          hy_r <= {32'd0, magy_r[48:32]} * {17'd0, coef_r};
          lx_r <= {32'd0, magx_r[31:0]} * {32'd0, coef_r};
          ly_r <= {32'd0, magy_r[31:0]} * {32'd0, coef_r};
          st_r <= F_COMB;
        end
        F_COMB: begin
          wx_r <= negx_r ? -$signed(rx[63:0]) : $signed(rx[63:0]);
          wy_r <= negy_r ? -$signed(ry[63:0]) : $signed(ry[63:0]);
          k_r  <= 2'd0;
          st_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            if (k_r == 2'd2) begin
              vcnt_r  <= 2'd0;
              partx_r <= '0;
              party_r <= '0;
              st_r    <= F_IDLE;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/nga_div.sv =====
// Restoring divider, one quotient bit per cycle for x and y together,
// giving (sum * 2^16) / area toward zero with saturation. Depends on nga_pkg.
`default_nettype none
module nga_div
  import nga_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  wire signed [SumW-1:0]  num_x,
  input  wire signed [SumW-1:0]  num_y,
  input  wire [AreaW-1:0]        area,
  output logic                   done,
  output logic [ValW-1:0]        q_x,
  output logic [ValW-1:0]        q_y
);

  localparam logic [34:0] QCap = 35'h2_0000_0000;

  logic              busy_r, done_r, negx_r, negy_r;
  logic [6:0]        cnt_r;
  logic [SumW-1:0]   mx_r, my_r;
  logic [AreaW:0]    rx_r, ry_r;
  logic [34:0]       qx_r, qy_r;
  logic [AreaW-1:0]  area_r;

  logic [AreaW+1:0]  rx2, ry2;
  logic [34:0]       qx2, qy2;

  function automatic logic [ValW-1:0] fin(input logic neg, input logic [34:0] q);
    logic [ValW-1:0] r;
    if (!neg) r = (q > 35'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    else if (q > 35'h8000_0000) r = 32'h8000_0000;
    else r = -q[31:0];
    return r;
  endfunction

  always_comb begin
    rx2 = {rx_r, mx_r[SumW-1]};
    ry2 = {ry_r, my_r[SumW-1]};
    qx2 = {qx_r[33:0], 1'b0};
    qy2 = {qy_r[33:0], 1'b0};
    if (rx2 >= {2'b0, area_r}) begin
      rx2 = rx2 - {2'b0, area_r};
      qx2[0] = 1'b1;
    end
    if (ry2 >= {2'b0, area_r}) begin
      ry2 = ry2 - {2'b0, area_r};
      qy2[0] = 1'b1;
    end
    if (qx_r[34:33] != 2'b00) qx2 = QCap;
    if (qy_r[34:33] != 2'b00) qy2 = QCap;
    if (qx2 > QCap) qx2 = QCap;
    if (qy2 > QCap) qy2 = QCap;
  end

  assign done = done_r;
  assign q_x  = fin(negx_r, qx_r);
  assign q_y  = fin(negy_r, qy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 7'(DivSteps - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        negx_r <= num_x[SumW-1];
        negy_r <= num_y[SumW-1];
        mx_r   <= num_x[SumW-1] ? -num_x : num_x;
        my_r   <= num_y[SumW-1] ? -num_y : num_y;
        rx_r   <= '0;
        ry_r   <= '0;
        qx_r   <= '0;
        qy_r   <= '0;
        area_r <= area;
      end else if (busy_r) begin
        mx_r <= {mx_r[SumW-2:0], 1'b0};
        my_r <= {my_r[SumW-2:0], 1'b0};
        rx_r <= rx2[AreaW:0];
        ry_r <= ry2[AreaW:0];
        qx_r <= qx2;
        qy_r <= qy2;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DivSteps - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/nga_back.sv =====
// Back part: owns the node memory, runs the clearing sweep, applies node
// commands and answers reads. Depends on nga_pkg and nga_div.
`default_nettype none
module nga_back
  import nga_pkg::*;
#(
  parameter int NODE_COUNT = NodeCountDef
)
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [ValW-1:0]        threshold,
  output logic                  clearing,
  input  cmd_t                  head,
  input  wire                   empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic signed [ValW-1:0] out_grad_x,
  output logic signed [ValW-1:0] out_grad_y,
  output logic                  out_area_small
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_DATA, B_DIV, B_OUT} bst_t;

  bst_t            st_r;
  cmd_t            cmd_r;
  ent_t            mem [NODE_COUNT];
  ent_t            rd_r, wdata;
  logic [AW-1:0]   clr_r, waddr;
  logic            we;
  logic            ov_r, small_r, rsmall_r;
  logic [ValW-1:0] gx_r, gy_r, rgx_r, rgy_r;
  logic            div_start, div_done;
  logic [ValW-1:0] dq_x, dq_y;

  logic [16:0]     head_ext, cmd_ext;
  logic            head_in;
  logic [AreaW:0]  area_sum;
  logic [SumW:0]   sx_sum, sy_sum;

  assign head_ext = {7'd0, head.node};
  assign cmd_ext  = {7'd0, cmd_r.node};
  assign head_in  = 32'(head.node) < NODE_COUNT;

  assign clearing = (st_r == B_CLR);
  assign pop      = (st_r == B_IDLE) && !empty;

  assign area_sum = {1'b0, rd_r.area} + {17'd0, cmd_r.coef};
  assign sx_sum   = {rd_r.sx[SumW-1], rd_r.sx} + {cmd_r.wx[SumW-1], cmd_r.wx};
  assign sy_sum   = {rd_r.sy[SumW-1], rd_r.sy} + {cmd_r.wy[SumW-1], cmd_r.wy};

  function automatic logic [SumW-1:0] sat(input logic [SumW:0] s);
    logic [SumW-1:0] r;
    if (s[SumW] != s[SumW-1]) r = s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    else r = s[SumW-1:0];
    return r;
  endfunction

  always_comb begin
    we    = 1'b0;
    waddr = cmd_ext[AW-1:0];
    wdata = '0;
    if (st_r == B_CLR) begin
      we    = 1'b1;
      waddr = clr_r;
    end else if (st_r == B_IDLE && !empty && head.op == OP_CLEAR && head_in) begin
      we    = 1'b1;
      waddr = head_ext[AW-1:0];
    end else if (st_r == B_DATA && cmd_r.op == OP_UPDATE) begin
      we         = 1'b1;
      wdata.area = area_sum[AreaW] ? AreaMax : area_sum[AreaW-1:0];
      wdata.sx   = sat(sx_sum);
      wdata.sy   = sat(sy_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[head_ext[AW-1:0]];
  end

  assign div_start = (st_r == B_DATA) && (cmd_r.op == OP_READ) &&
                     (rd_r.area > {16'd0, threshold});

  nga_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_x (rd_r.sx),
    .num_y (rd_r.sy),
    .area  (rd_r.area),
    .done  (div_done),
    .q_x   (dq_x),
    .q_y   (dq_y)
  );

  assign out_valid      = ov_r;
  assign out_grad_x     = gx_r;
  assign out_grad_y     = gy_r;
  assign out_area_small = small_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_CLR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (ov_r && !out_stall && st_r != B_OUT) ov_r <= 1'b0;
      unique case (st_r)
        B_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(NODE_COUNT - 1)) st_r <= B_IDLE;
        end
        B_IDLE: begin
          if (!empty) begin
            cmd_r <= head;
            if (head.op == OP_CLEAR) begin
              st_r <= B_IDLE;
            end else if (head_in) begin
              st_r <= B_DATA;
            end else if (head.op == OP_READ) begin
              rgx_r    <= '0;
              rgy_r    <= '0;
              rsmall_r <= 1'b1;
              st_r     <= B_OUT;
            end
          end
        end
        B_DATA: begin
          if (cmd_r.op == OP_UPDATE) begin
            st_r <= B_IDLE;
          end else if (div_start) begin
            st_r <= B_DIV;
          end else begin
            rgx_r    <= '0;
            rgy_r    <= '0;
            rsmall_r <= 1'b1;
            st_r     <= B_OUT;
          end
        end
        B_DIV: begin
          if (div_done) begin
            rgx_r    <= dq_x;
            rgy_r    <= dq_y;
            rsmall_r <= 1'b0;
            st_r     <= B_OUT;
          end
        end
        B_OUT: begin
          if (!ov_r || !out_stall) begin
            ov_r    <= 1'b1;
            gx_r    <= rgx_r;
            gy_r    <= rgy_r;
            small_r <= rsmall_r;
            st_r    <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/nga_check.sv =====
// Port-level checks for the nodal gradient area averaging unit, bound to
// the top level. Depends only on the top level's ports.
`default_nettype none
module nga_check (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] out_grad_x,
  input wire [31:0] out_grad_y,
  input wire        out_area_small,
  input wire        in_stall
);

  // A small-area result always carries zero gradients.
  a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_area_small |-> out_grad_x == 32'd0 && out_grad_y == 32'd0)
    else $error("small area result with nonzero gradient");

  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The clearing sweep blocks requests right after reset.
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("requests accepted during clearing sweep");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_grad_x) && $stable(out_grad_y))
    else $error("stalled result changed");

endmodule

bind nodal_gradient_area_average_unit nga_check u_nga_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_grad_x     (out_grad_x),
  .out_grad_y     (out_grad_y),
  .out_area_small (out_area_small),
  .in_stall       (in_stall)
);
`default_nettype wire
